>>> rtl/core/sfp_pkg.sv
// Shared types, constants and arithmetic helpers for the starfield projection and splat block.
package sfp_pkg;

  localparam int FIELD_DEPTH = 256;
  localparam int COORD_LIMIT = 1024;
  localparam int MAX_RES     = 1024;

  localparam int PERSP_BASE  = 8192;
  localparam int PERSP_SCALE = PERSP_BASE / 256;
  localparam int BRIGHT_FULL = 64;
  localparam int SUB_MASK    = 15;
  localparam int SUB_BITS    = 4;

  localparam int RES_W    = 11;
  localparam int ADDR_W   = 20;
  localparam int INC_W    = 6;
  localparam int COORD_W  = 12;
  localparam int Z_W      = 8;
  localparam int TIME_W   = 16;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 1;

  // Depth, numerator and divider geometry
  localparam int WZ_W       = $clog2(FIELD_DEPTH);
  localparam int NUM_W      = $clog2(COORD_LIMIT * PERSP_SCALE + 1);
  localparam int DIV_STAGES = 4;
  localparam int DIV_BPS    = (NUM_W + DIV_STAGES - 1) / DIV_STAGES;
  localparam int QW         = DIV_STAGES * DIV_BPS;

  localparam int COL_W  = $clog2(BRIGHT_FULL + 1);
  localparam int POS_W  = ((QW > RES_W + 3) ? QW : RES_W + 3) + 2;
  localparam int PX_W   = RES_W + SUB_BITS;
  localparam int MUL_W  = PX_W - SUB_BITS + RES_W;
  localparam int SXP_W  = COL_W + SUB_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [RES_W-1:0] screen_width;
    logic [RES_W-1:0] screen_height;
  } cfg_t;

  // Divider payload: num shifts out dividend bits and collects quotient bits
  typedef struct packed {
    logic            negx;
    logic            negy;
    logic [QW-1:0]   numx;
    logic [QW-1:0]   numy;
    logic [WZ_W-1:0] remx;
    logic [WZ_W-1:0] remy;
    logic [WZ_W-1:0] wz;
  } div_t;

  typedef struct packed {
    logic [WZ_W-1:0] rem;
    logic [QW-1:0]   num;
  } dstep_t;

  typedef struct packed {
    logic [3:0][ADDR_W-1:0] addr;
    logic [3:0][INC_W-1:0]  inc;
  } quad_t;

  // One restoring division step
  function automatic dstep_t div_one(dstep_t s, logic [WZ_W-1:0] wz);
    logic [WZ_W:0] t;
    dstep_t r;
    t = {s.rem, s.num[QW-1]};
    r.num = s.num << 1;
    if (t >= {1'b0, wz}) begin
      r.rem    = WZ_W'(t - {1'b0, wz});
      r.num[0] = 1'b1;
    end else begin
      r.rem = t[WZ_W-1:0];
    end
    return r;
  endfunction

  // DIV_BPS quotient bits for both coordinates
  function automatic div_t div_bits(div_t d);
    div_t   r;
    dstep_t sx;
    dstep_t sy;
    r  = d;
    sx = '{rem: d.remx, num: d.numx};
    sy = '{rem: d.remy, num: d.numy};
    for (int k = 0; k < DIV_BPS; k++) begin
      sx = div_one(sx, d.wz);
      sy = div_one(sy, d.wz);
    end
    r.numx = sx.num;
    r.remx = sx.rem;
    r.numy = sy.num;
    r.remy = sy.rem;
    return r;
  endfunction

endpackage

>>> rtl/core/sfp_div.sv
// Pipelined restoring divider for both projected coordinates by the star depth.
module sfp_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfp_pkg::div_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sfp_pkg::div_t    out_data
);

  logic [sfp_pkg::DIV_STAGES-1:0] vld;
  sfp_pkg::div_t                  stg [sfp_pkg::DIV_STAGES];
  logic [sfp_pkg::DIV_STAGES:0]   rdy;
  logic [sfp_pkg::DIV_STAGES:0]   pv;
  sfp_pkg::div_t                  pd  [sfp_pkg::DIV_STAGES+1];

  assign pv[0]    = in_valid;
  assign pd[0]    = in_data;
  assign rdy[sfp_pkg::DIV_STAGES] = out_ready;
  assign in_ready = rdy[0];

  for (genvar i = 0; i < sfp_pkg::DIV_STAGES; i++) begin : g_stage
    assign rdy[i]   = !vld[i] || rdy[i+1];
    assign pv[i+1]  = vld[i];
    assign pd[i+1]  = stg[i];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= pv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        stg[i] <= sfp_pkg::div_bits(pd[i]);
      end
    end
  end

  assign out_valid = vld[sfp_pkg::DIV_STAGES-1];
  assign out_data  = stg[sfp_pkg::DIV_STAGES-1];

endmodule

>>> rtl/core/sfp_splat.sv
// Screen placement, clipping, brightness and bilinear weights over three stages.
module sfp_splat (
  input  logic             clk,
  input  logic             rst,
  input  sfp_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfp_pkg::div_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sfp_pkg::quad_t   out_data
);

  // Stage A: position and clip
  logic                          va, ra;
  logic [sfp_pkg::PX_W-1:0]      a_px, a_py;
  logic [sfp_pkg::COL_W-1:0]     a_col;
  // Stage B: subpixel weight and base address
  logic                          vb, rb;
  logic [sfp_pkg::ADDR_W-1:0]    b_base;
  logic [sfp_pkg::COL_W-1:0]     b_sx, b_col;
  logic [sfp_pkg::SUB_BITS-1:0]  b_sy;
  // Stage C: the four results
  logic                          vc, rc;
  sfp_pkg::quad_t                c_quad;

  logic signed [sfp_pkg::POS_W-1:0] qx, qy, px, py, limx, limy;
  logic                             visible;
  logic [sfp_pkg::COL_W-1:0]        col;
  logic [sfp_pkg::MUL_W-1:0]        row_prod;
  logic [sfp_pkg::SXP_W-1:0]        sx_prod;
  logic [sfp_pkg::COL_W-1:0]        cs;
  logic [sfp_pkg::SUB_BITS-1:0]     isy;
  logic [sfp_pkg::SXP_W-1:0]        p0, p1, p2, p3;
  logic [sfp_pkg::ADDR_W-1:0]       w_addr;
  sfp_pkg::quad_t                   quad_next;

  assign rc       = !vc || out_ready;
  assign rb       = !vb || rc;
  assign ra       = !va || rb;
  assign in_ready = ra;

  always_comb begin
    qx = in_data.negx ? -sfp_pkg::POS_W'(in_data.numx) : sfp_pkg::POS_W'(in_data.numx);
    qy = in_data.negy ? -sfp_pkg::POS_W'(in_data.numy) : sfp_pkg::POS_W'(in_data.numy);
    px = sfp_pkg::POS_W'({cfg.screen_width, 3'b000}) + qx;
    py = sfp_pkg::POS_W'({cfg.screen_height, 3'b000}) + qy;
    limx = (sfp_pkg::POS_W'(cfg.screen_width) - sfp_pkg::POS_W'(2)) <<< sfp_pkg::SUB_BITS;
    limy = (sfp_pkg::POS_W'(cfg.screen_height) - sfp_pkg::POS_W'(2)) <<< sfp_pkg::SUB_BITS;
    visible = !px[sfp_pkg::POS_W-1] && !py[sfp_pkg::POS_W-1] && (px < limx) && (py < limy);
    col = sfp_pkg::COL_W'(sfp_pkg::BRIGHT_FULL
          - (int'(in_data.wz) * sfp_pkg::BRIGHT_FULL) / sfp_pkg::FIELD_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ra) begin
      va <= in_valid && visible;
    end
  end

  always_ff @(posedge clk) begin
    if (ra) begin
      a_px  <= sfp_pkg::PX_W'(px);
      a_py  <= sfp_pkg::PX_W'(py);
      a_col <= col;
    end
  end

  always_comb begin
    row_prod = sfp_pkg::MUL_W'(a_py[sfp_pkg::PX_W-1:sfp_pkg::SUB_BITS])
             * sfp_pkg::MUL_W'(cfg.screen_width);
    sx_prod  = sfp_pkg::SXP_W'(a_px[sfp_pkg::SUB_BITS-1:0]) * sfp_pkg::SXP_W'(a_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rb) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rb) begin
      b_base <= sfp_pkg::ADDR_W'(row_prod
                + sfp_pkg::MUL_W'(a_px[sfp_pkg::PX_W-1:sfp_pkg::SUB_BITS]));
      b_sx   <= sfp_pkg::COL_W'(sx_prod >> sfp_pkg::SUB_BITS);
      b_sy   <= a_py[sfp_pkg::SUB_BITS-1:0];
      b_col  <= a_col;
    end
  end

  always_comb begin
    cs     = b_col - b_sx;
    isy    = sfp_pkg::SUB_BITS'(sfp_pkg::SUB_MASK) - b_sy;
    p0     = sfp_pkg::SXP_W'(cs) * sfp_pkg::SXP_W'(isy);
    p1     = sfp_pkg::SXP_W'(b_sx) * sfp_pkg::SXP_W'(isy);
    p2     = sfp_pkg::SXP_W'(cs) * sfp_pkg::SXP_W'(b_sy);
    p3     = sfp_pkg::SXP_W'(b_sx) * sfp_pkg::SXP_W'(b_sy);
    w_addr = sfp_pkg::ADDR_W'(cfg.screen_width);
    quad_next.inc[0]  = sfp_pkg::INC_W'(p0 >> sfp_pkg::SUB_BITS);
    quad_next.inc[1]  = sfp_pkg::INC_W'(p1 >> sfp_pkg::SUB_BITS);
    quad_next.inc[2]  = sfp_pkg::INC_W'(p2 >> sfp_pkg::SUB_BITS);
    quad_next.inc[3]  = sfp_pkg::INC_W'(p3 >> sfp_pkg::SUB_BITS);
    quad_next.addr[0] = b_base;
    quad_next.addr[1] = b_base + sfp_pkg::ADDR_W'(1);
    quad_next.addr[2] = b_base + w_addr;
    quad_next.addr[3] = b_base + w_addr + sfp_pkg::ADDR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (rc) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (rc) begin
      c_quad <= quad_next;
    end
  end

  assign out_valid = vc;
  assign out_data  = c_quad;

endmodule

>>> rtl/core/sfp_serial.sv
// Output register that hands out the four pixel increments of a star one per request.
module sfp_serial (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sfp_pkg::quad_t                    in_data,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sfp_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tlast
);

  logic           vld;
  logic [1:0]     idx;
  sfp_pkg::quad_t quad;
  logic           last;

  assign last     = (idx == 2'd3);
  assign in_ready = !vld || (m_tready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
      idx <= 2'd0;
    end else if (in_ready) begin
      vld <= in_valid;
      idx <= 2'd0;
    end else if (m_tready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      quad <= in_data;
    end
  end

  assign m_tvalid = vld;
  assign m_tlast  = last;
  assign m_tdata  = sfp_pkg::OUT_TDATA_W'({quad.inc[idx], quad.addr[idx]});

endmodule

>>> rtl/core/starfield_project_splat.sv
// Top level: star intake, depth and divider setup, configuration and pipeline wiring.
//
//   channel   direction  handshake          contents
//   s_*       in         tvalid/tready      one star per request
//   m_*       out        tvalid/tready      one pixel increment per request, tlast on fourth
//   cfg_*     in         cfg_we             screen_width / screen_height write
//
// From request to result a star passes intake, four divider stages of four quotient bits
// each, three splat stages and the output register. A visible star occupies the single
// result port until its four increments are taken; stars with zero depth or off screen
// drop inside the pipeline and pass at one per cycle while no stage ahead of them stalls.
// Reset (rst, synchronous) clears all valid bits and loads width 320, height 256. A stall
// on m_tready holds a full stage only if every stage after it is full.
module starfield_project_splat (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // star_x[11:0], star_y[23:12], star_z[31:24], frame_time[47:32]
  input  logic [sfp_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // pixel_address[19:0], increment[25:20], zero fill above
  output logic [sfp_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfp_pkg::RES_W-1:0]          cfg_data
);

  logic [sfp_pkg::RES_W-1:0] screen_width, screen_height, cfg_sat;
  sfp_pkg::cfg_t             cfg;

  logic          e_vld, e_rdy;
  sfp_pkg::div_t e_data, e_next;
  logic          d_vld, d_rdy;
  sfp_pkg::div_t d_data;
  logic          q_vld, q_rdy;
  sfp_pkg::quad_t q_data;

  int cx, cy, zm, tm, diff;

  // Saturate writes to the largest supported resolution
  assign cfg_sat = (int'(cfg_data) > sfp_pkg::MAX_RES) ? sfp_pkg::RES_W'(sfp_pkg::MAX_RES)
                                                        : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= sfp_pkg::RES_W'(320);
      screen_height <= sfp_pkg::RES_W'(256);
    end else if (cfg_we) begin
      unique case (sfp_pkg::cfg_reg_t'(cfg_index))
        sfp_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_sat;
        sfp_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_sat;
        default: ;
      endcase
    end
  end

  assign cfg.screen_width  = screen_width;
  assign cfg.screen_height = screen_height;

  // Intake: clamp coordinates, scale magnitudes, wrap depth
  always_comb begin
    cx = int'($signed(s_tdata[sfp_pkg::COORD_W-1:0]));
    cy = int'($signed(s_tdata[2*sfp_pkg::COORD_W-1:sfp_pkg::COORD_W]));
    if (cx > sfp_pkg::COORD_LIMIT)  cx = sfp_pkg::COORD_LIMIT;
    if (cx < -sfp_pkg::COORD_LIMIT) cx = -sfp_pkg::COORD_LIMIT;
    if (cy > sfp_pkg::COORD_LIMIT)  cy = sfp_pkg::COORD_LIMIT;
    if (cy < -sfp_pkg::COORD_LIMIT) cy = -sfp_pkg::COORD_LIMIT;
    zm = int'(s_tdata[31:24]) % sfp_pkg::FIELD_DEPTH;
    tm = int'(s_tdata[47:32]) % sfp_pkg::FIELD_DEPTH;
    diff = zm - tm;
    if (diff < 0) diff = diff + sfp_pkg::FIELD_DEPTH;
    e_next.negx = (cx < 0);
    e_next.negy = (cy < 0);
    e_next.numx = sfp_pkg::QW'(((cx < 0) ? -cx : cx) * sfp_pkg::PERSP_SCALE);
    e_next.numy = sfp_pkg::QW'(((cy < 0) ? -cy : cy) * sfp_pkg::PERSP_SCALE);
    e_next.remx = '0;
    e_next.remy = '0;
    e_next.wz   = sfp_pkg::WZ_W'(diff);
  end

  assign e_rdy    = !e_vld || d_rdy;
  assign s_tready = e_rdy;

  // Drop a star at zero depth right here
  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (e_rdy) begin
      e_vld <= s_tvalid && (e_next.wz != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (e_rdy) begin
      e_data <= e_next;
    end
  end

  sfp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e_vld),
    .in_ready  (d_rdy),
    .in_data   (e_data),
    .out_valid (d_vld),
    .out_ready (q_rdy),
    .out_data  (d_data)
  );

  logic s_rdy;

  sfp_splat u_splat (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (d_vld),
    .in_ready  (q_rdy),
    .in_data   (d_data),
    .out_valid (q_vld),
    .out_ready (s_rdy),
    .out_data  (q_data)
  );

  sfp_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_vld),
    .in_ready (s_rdy),
    .in_data  (q_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
